// ===== rtl/ptu_pkg.sv =====
package ptu_pkg;

  localparam int ENTRIES_PER_PAGE = 1024;
  localparam int ENTRY_W          = $clog2(ENTRIES_PER_PAGE);
  localparam int STORE_PAGES      = 64;
  localparam int FRAME_W          = 20;
  localparam int PAGE_SHIFT       = 12;
  localparam int WORD_W           = 32;
  localparam int FUNC_W           = 2;
  localparam int ATTR_W           = 12;
  localparam int STATUS_W         = 2;
  localparam int CFG_IDX_W        = 2;
  localparam int IN_DATA_W        = 112;
  localparam int OUT_DATA_W       = 40;

  localparam logic [FRAME_W-1:0] STORE_BASE_RST  = 20'd256;
  localparam logic [FRAME_W-1:0] ALLOC_FIRST_RST = 20'd256;
  localparam logic [FRAME_W-1:0] ALLOC_LAST_RST  = 20'd319;

  localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_FIRST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_LAST  = 2'd2;

  localparam logic [FUNC_W-1:0] FN_MAP   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_UNMAP = 2'd1;
  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NONE  = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OUTSIDE   = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_INPUT, C_FUNC_ALLOC, C_FUNC_NONE, C_FUNC_UNMAP,
    C_DIR_OUT, C_PDE_SET, C_TAB_OUT, C_EXH, C_NF_OUT, C_CLR_MORE,
    C_SWEEP_MORE, C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {A_DIR, A_TAB, A_CLR, A_SWEEP} addr_sel_t;
  typedef enum logic [1:0] {W_ZERO, W_PDE, W_PTE} wdata_sel_t;

  localparam int UPC_W = 5;

  localparam logic [UPC_W-1:0] S_SWEEP = 5'd0;
  localparam logic [UPC_W-1:0] S_IDLE  = 5'd1;
  localparam logic [UPC_W-1:0] S_DISP  = 5'd2;
  localparam logic [UPC_W-1:0] S_CHK   = 5'd3;
  localparam logic [UPC_W-1:0] S_RDDIR = 5'd4;
  localparam logic [UPC_W-1:0] S_LDPDE = 5'd5;
  localparam logic [UPC_W-1:0] S_SPLIT = 5'd6;
  localparam logic [UPC_W-1:0] S_MAP   = 5'd7;
  localparam logic [UPC_W-1:0] S_MEXH  = 5'd8;
  localparam logic [UPC_W-1:0] S_MNOUT = 5'd9;
  localparam logic [UPC_W-1:0] S_MTAKE = 5'd10;
  localparam logic [UPC_W-1:0] S_MCLR  = 5'd11;
  localparam logic [UPC_W-1:0] S_MJMP  = 5'd12;
  localparam logic [UPC_W-1:0] S_MHAVE = 5'd13;
  localparam logic [UPC_W-1:0] S_MWDIR = 5'd14;
  localparam logic [UPC_W-1:0] S_MWTAB = 5'd15;
  localparam logic [UPC_W-1:0] S_UNMAP = 5'd16;
  localparam logic [UPC_W-1:0] S_URES  = 5'd17;
  localparam logic [UPC_W-1:0] S_ALLOC = 5'd18;
  localparam logic [UPC_W-1:0] S_ANOUT = 5'd19;
  localparam logic [UPC_W-1:0] S_ATAKE = 5'd20;
  localparam logic [UPC_W-1:0] S_ACLR  = 5'd21;
  localparam logic [UPC_W-1:0] S_ARES  = 5'd22;
  localparam logic [UPC_W-1:0] S_ERR1  = 5'd23;
  localparam logic [UPC_W-1:0] S_ERR2  = 5'd24;
  localparam logic [UPC_W-1:0] S_FIN   = 5'd25;
  localparam logic [UPC_W-1:0] S_NEXT  = 5'd26;

  typedef struct packed {
    cond_t            cond;
    logic [UPC_W-1:0] target;
    addr_sel_t        asel;
    wdata_sel_t       wsel;
    logic             mem_we;
    logic             accept;
    logic             ld_pde;
    logic             ld_tab;
    logic             take;
    logic             cnt_inc;
    logic             set_flush;
    logic             res_rd;
    logic             res_alloc;
    logic             set_status;
    status_t          status;
    logic             out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic func_alloc;
    logic func_none;
    logic func_unmap;
    logic dir_out;
    logic pde_set;
    logic tab_out;
    logic exh;
    logic nf_out;
    logic clr_more;
    logic sweep_more;
    logic out_busy;
  } flags_t;

  // microprogram
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] step);
    ctrl_t cw;
    cw = '0;
    case (step)
      S_SWEEP: begin
        cw.mem_we = 1'b1; cw.asel = A_SWEEP; cw.wsel = W_ZERO; cw.cnt_inc = 1'b1;
        cw.cond = C_SWEEP_MORE; cw.target = S_SWEEP;
      end
      S_IDLE: begin
        cw.accept = 1'b1; cw.cond = C_NO_INPUT; cw.target = S_IDLE;
      end
      S_DISP: begin
        cw.cond = C_FUNC_ALLOC; cw.target = S_ALLOC;
      end
      S_CHK: begin
        cw.cond = C_FUNC_NONE; cw.target = S_FIN;
      end
      S_RDDIR: begin
        cw.asel = A_DIR; cw.cond = C_DIR_OUT; cw.target = S_ERR1;
      end
      S_LDPDE: begin
        cw.ld_pde = 1'b1;
      end
      S_SPLIT: begin
        cw.ld_tab = 1'b1; cw.cond = C_FUNC_UNMAP; cw.target = S_UNMAP;
      end
      S_MAP: begin
        cw.cond = C_PDE_SET; cw.target = S_MHAVE;
      end
      S_MEXH: begin
        cw.cond = C_EXH; cw.target = S_ERR2;
      end
      S_MNOUT: begin
        cw.cond = C_NF_OUT; cw.target = S_ERR1;
      end
      S_MTAKE: begin
        cw.take = 1'b1;
      end
      S_MCLR: begin
        cw.mem_we = 1'b1; cw.asel = A_CLR; cw.wsel = W_ZERO; cw.cnt_inc = 1'b1;
        cw.cond = C_CLR_MORE; cw.target = S_MCLR;
      end
      S_MJMP: begin
        cw.cond = C_ALWAYS; cw.target = S_MWDIR;
      end
      S_MHAVE: begin
        cw.cond = C_TAB_OUT; cw.target = S_ERR1;
      end
      S_MWDIR: begin
        cw.mem_we = 1'b1; cw.asel = A_DIR; cw.wsel = W_PDE; cw.set_flush = 1'b1;
      end
      S_MWTAB: begin
        cw.mem_we = 1'b1; cw.asel = A_TAB; cw.wsel = W_PTE;
        cw.cond = C_ALWAYS; cw.target = S_FIN;
      end
      S_UNMAP: begin
        cw.asel = A_TAB; cw.cond = C_TAB_OUT; cw.target = S_ERR1;
      end
      S_URES: begin
        cw.res_rd = 1'b1; cw.mem_we = 1'b1; cw.asel = A_TAB; cw.wsel = W_ZERO;
        cw.set_flush = 1'b1; cw.cond = C_ALWAYS; cw.target = S_FIN;
      end
      S_ALLOC: begin
        cw.cond = C_EXH; cw.target = S_ERR2;
      end
      S_ANOUT: begin
        cw.cond = C_NF_OUT; cw.target = S_ERR1;
      end
      S_ATAKE: begin
        cw.take = 1'b1;
      end
      S_ACLR: begin
        cw.mem_we = 1'b1; cw.asel = A_CLR; cw.wsel = W_ZERO; cw.cnt_inc = 1'b1;
        cw.cond = C_CLR_MORE; cw.target = S_ACLR;
      end
      S_ARES: begin
        cw.res_alloc = 1'b1; cw.cond = C_ALWAYS; cw.target = S_FIN;
      end
      S_ERR1: begin
        cw.set_status = 1'b1; cw.status = ST_OUTSIDE;
        cw.cond = C_ALWAYS; cw.target = S_FIN;
      end
      S_ERR2: begin
        cw.set_status = 1'b1; cw.status = ST_EXHAUSTED;
        cw.cond = C_ALWAYS; cw.target = S_FIN;
      end
      S_FIN: begin
        cw.out_load = 1'b1; cw.cond = C_OUT_BUSY; cw.target = S_FIN;
      end
      S_NEXT: begin
        cw.cond = C_ALWAYS; cw.target = S_IDLE;
      end
      default: begin
        cw.cond = C_ALWAYS; cw.target = S_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/two_level_page_table_updater.sv =====
// A map that creates a table and an allocate each clear a page (1024 store writes
// through the single store port), so they take the longest; func 3 makes no access.
// One transaction at a time; the next is taken after the result register is loaded.
// Reset (synchronous, rst_n low) starts a clearing pass over all STORE_PAGES*1024
// words (65536 by default); no input is taken until it ends, configuration writes are.
module two_level_page_table_updater #(
  parameter int STORE_PAGES = ptu_pkg::STORE_PAGES,
  localparam int ADDR_W = $clog2(STORE_PAGES) + ptu_pkg::ENTRY_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input: [1:0] func, [33:2] dir_address, [65:34] virt_address,
  //        [97:66] phys_address, [109:98] attributes, [111:110] zero
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ptu_pkg::IN_DATA_W-1:0]   in_tdata,
  // result: [31:0] result_address, [33:32] status, [34] tlb_flush, [39:35] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ptu_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [ptu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptu_pkg::FRAME_W-1:0]     cfg_wdata
);

  logic [ptu_pkg::FRAME_W-1:0] store_base_r;
  logic [ptu_pkg::FRAME_W-1:0] alloc_last_r;

  ptu_pkg::ctrl_t  ctrl;
  ptu_pkg::flags_t flags;

  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_addr;
  logic [ptu_pkg::WORD_W-1:0] mem_wdata;
  logic [ptu_pkg::WORD_W-1:0] mem_rdata;

  // Configuration registers. alloc_first_frame only fixes the allocator's value
  // at reset; a later write leaves the allocator alone, so it is not stored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_base_r <= ptu_pkg::STORE_BASE_RST;
      alloc_last_r <= ptu_pkg::ALLOC_LAST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ptu_pkg::CFG_STORE_BASE:  store_base_r <= cfg_wdata;
        ptu_pkg::CFG_ALLOC_FIRST: ;
        ptu_pkg::CFG_ALLOC_LAST:  alloc_last_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: one control word per step; IDLE step raises in_tready.
  ptu_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign in_tready = ctrl.accept;

  // Datapath: frame offset checks, address generation, allocator, result
  // register (a result may wait there while the next transaction starts).
  ptu_dpath #(
    .STORE_PAGES (STORE_PAGES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .flags      (flags),
    .store_base (store_base_r),
    .alloc_last (alloc_last_r),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

  // Page store: STORE_PAGES pages of 1024 words, one access per cycle.
  ptu_store #(
    .STORE_PAGES (STORE_PAGES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

// ===== rtl/ptu_store.sv =====
// single-port word store, registered read
module ptu_store #(
  parameter int STORE_PAGES = ptu_pkg::STORE_PAGES,
  localparam int DEPTH  = STORE_PAGES * ptu_pkg::ENTRIES_PER_PAGE,
  localparam int ADDR_W = $clog2(STORE_PAGES) + ptu_pkg::ENTRY_W
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         addr,
  input  logic [ptu_pkg::WORD_W-1:0] wdata,
  output logic [ptu_pkg::WORD_W-1:0] rdata
);

  logic [ptu_pkg::WORD_W-1:0] mem [DEPTH];
  logic [ptu_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ptu_useq.sv =====
// microprogram sequencer: step counter, control ROM, conditional jump
module ptu_useq (
  input  logic            clk,
  input  logic            rst_n,
  input  ptu_pkg::flags_t flags,
  output ptu_pkg::ctrl_t  ctrl
);

  logic [ptu_pkg::UPC_W-1:0] upc_r;
  logic [ptu_pkg::UPC_W-1:0] upc_nxt;
  ptu_pkg::ctrl_t            cw;
  logic                      taken;

  assign cw = ptu_pkg::ucode(upc_r);

  always_comb begin
    case (cw.cond)
      ptu_pkg::C_NEVER:      taken = 1'b0;
      ptu_pkg::C_ALWAYS:     taken = 1'b1;
      ptu_pkg::C_NO_INPUT:   taken = ~flags.in_valid;
      ptu_pkg::C_FUNC_ALLOC: taken = flags.func_alloc;
      ptu_pkg::C_FUNC_NONE:  taken = flags.func_none;
      ptu_pkg::C_FUNC_UNMAP: taken = flags.func_unmap;
      ptu_pkg::C_DIR_OUT:    taken = flags.dir_out;
      ptu_pkg::C_PDE_SET:    taken = flags.pde_set;
      ptu_pkg::C_TAB_OUT:    taken = flags.tab_out;
      ptu_pkg::C_EXH:        taken = flags.exh;
      ptu_pkg::C_NF_OUT:     taken = flags.nf_out;
      ptu_pkg::C_CLR_MORE:   taken = flags.clr_more;
      ptu_pkg::C_SWEEP_MORE: taken = flags.sweep_more;
      ptu_pkg::C_OUT_BUSY:   taken = flags.out_busy;
      default:               taken = 1'b0;
    endcase
  end

  assign upc_nxt = taken ? cw.target : upc_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ptu_pkg::S_SWEEP;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctrl = cw;

endmodule

// ===== rtl/ptu_dpath.sv =====
// datapath: operand registers, frame checks, store addressing, result register
module ptu_dpath #(
  parameter int STORE_PAGES = ptu_pkg::STORE_PAGES,
  localparam int PAW    = $clog2(STORE_PAGES),
  localparam int ADDR_W = PAW + ptu_pkg::ENTRY_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ptu_pkg::ctrl_t                ctrl,
  output ptu_pkg::flags_t               flags,
  input  logic [ptu_pkg::FRAME_W-1:0]   store_base,
  input  logic [ptu_pkg::FRAME_W-1:0]   alloc_last,
  input  logic                          in_tvalid,
  input  logic [ptu_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [ptu_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          mem_we,
  output logic [ADDR_W-1:0]             mem_addr,
  output logic [ptu_pkg::WORD_W-1:0]    mem_wdata,
  input  logic [ptu_pkg::WORD_W-1:0]    mem_rdata
);

  localparam int FW = ptu_pkg::FRAME_W;
  localparam int EW = ptu_pkg::ENTRY_W;
  localparam int WW = ptu_pkg::WORD_W;
  localparam int PS = ptu_pkg::PAGE_SHIFT;
  localparam logic [FW-1:0]     PAGES_F  = FW'(STORE_PAGES);
  localparam logic [ADDR_W-1:0] LAST_W   = ADDR_W'(STORE_PAGES * ptu_pkg::ENTRIES_PER_PAGE - 1);
  localparam logic [EW-1:0]     LAST_ENT = '1;

  logic [ptu_pkg::FUNC_W-1:0]   func_r;
  logic [FW-1:0]                dir_frame_r;
  logic [EW-1:0]                dir_idx_r;
  logic [EW-1:0]                tab_idx_r;
  logic [FW-1:0]                phys_hi_r;
  logic [ptu_pkg::ATTR_W-1:0]   attr_r;
  logic [WW-1:0]                pde_r;
  logic [FW-1:0]                tab_frame_r;
  logic [FW-1:0]                next_free_r;
  logic [ADDR_W-1:0]            cnt_r;
  logic [WW-1:0]                res_r;
  logic [ptu_pkg::STATUS_W-1:0] status_r;
  logic                         flush_r;
  logic                         out_tvalid_r;
  logic [ptu_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [FW-1:0] dir_off;
  logic [FW-1:0] tab_off;
  logic [FW-1:0] nf_off;
  logic          in_fire;
  logic          out_busy;
  logic          out_load;

  assign in_fire  = ctrl.accept & in_tvalid;
  assign out_busy = out_tvalid_r & ~out_tready;
  assign out_load = ctrl.out_load & ~out_busy;

  // offsets from the first held frame, modulo 2^20
  assign dir_off = dir_frame_r - store_base;
  assign tab_off = tab_frame_r - store_base;
  assign nf_off  = next_free_r - store_base;

  always_comb begin
    flags.in_valid   = in_tvalid;
    flags.func_alloc = (func_r == ptu_pkg::FN_ALLOC);
    flags.func_none  = (func_r == ptu_pkg::FN_NONE);
    flags.func_unmap = (func_r == ptu_pkg::FN_UNMAP);
    flags.dir_out    = ~(dir_off < PAGES_F);
    flags.pde_set    = (pde_r != '0);
    flags.tab_out    = ~(tab_off < PAGES_F);
    flags.exh        = (next_free_r > alloc_last);
    flags.nf_out     = ~(nf_off < PAGES_F);
    flags.clr_more   = (cnt_r[EW-1:0] != LAST_ENT);
    flags.sweep_more = (cnt_r != LAST_W);
    flags.out_busy   = out_busy;
  end

  always_comb begin
    case (ctrl.asel)
      ptu_pkg::A_DIR:   mem_addr = {dir_off[PAW-1:0], dir_idx_r};
      ptu_pkg::A_TAB:   mem_addr = {tab_off[PAW-1:0], tab_idx_r};
      ptu_pkg::A_CLR:   mem_addr = {tab_off[PAW-1:0], cnt_r[EW-1:0]};
      ptu_pkg::A_SWEEP: mem_addr = cnt_r;
      default:          mem_addr = cnt_r;
    endcase
  end

  always_comb begin
    case (ctrl.wsel)
      ptu_pkg::W_ZERO: mem_wdata = '0;
      ptu_pkg::W_PDE:  mem_wdata = pde_r | {{(WW-ptu_pkg::ATTR_W){1'b0}}, attr_r};
      ptu_pkg::W_PTE:  mem_wdata = {phys_hi_r, attr_r};
      default:         mem_wdata = '0;
    endcase
  end

  assign mem_we = ctrl.mem_we;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r  <= ptu_pkg::ALLOC_FIRST_RST;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (ctrl.take) next_free_r <= next_free_r + 1'b1;
      if (ctrl.cnt_inc) cnt_r <= cnt_r + 1'b1;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r      <= in_tdata[1:0];
      dir_frame_r <= in_tdata[33:14];
      dir_idx_r   <= in_tdata[65:56];
      tab_idx_r   <= in_tdata[55:46];
      phys_hi_r   <= in_tdata[97:78];
      attr_r      <= in_tdata[109:98];
    end
    if (ctrl.ld_pde) pde_r <= mem_rdata;
    if (ctrl.take)   pde_r <= {next_free_r, {(PS-1){1'b0}}, 1'b1};
    if (ctrl.ld_tab) tab_frame_r <= pde_r[WW-1:PS];
    if (ctrl.take)   tab_frame_r <= next_free_r;
    if (in_fire) begin
      res_r    <= '0;
      status_r <= ptu_pkg::ST_OK;
      flush_r  <= 1'b0;
    end
    if (ctrl.res_rd)     res_r    <= {mem_rdata[WW-1:PS], {PS{1'b0}}};
    if (ctrl.res_alloc)  res_r    <= {tab_frame_r, {PS{1'b0}}};
    if (ctrl.set_status) status_r <= ctrl.status;
    if (ctrl.set_flush)  flush_r  <= 1'b1;
    if (out_load) out_data_r <= {5'b0, flush_r, status_r, res_r};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

endmodule
